// ===== rtl/sbf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants of the serial-bus frame decoder.
// ----------------------------------------------------------------------------
package sbf_pkg;

  // frame markers
  localparam logic [7:0] HDR_BYTE   = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;
  localparam logic [3:0] END_NIBBLE = 4'h4;

  // frame layout
  localparam int unsigned NUM_CH      = 16;
  localparam int unsigned CH_W        = 11;
  localparam int unsigned PAYLOAD_W   = NUM_CH * CH_W;  // bytes 1 to 22
  localparam int unsigned PAYLOAD_LEN = PAYLOAD_W / 8;
  localparam logic [4:0]  FOOTER_SLOT = 5'd24;
  localparam logic [3:0]  LAST_CH     = 4'(NUM_CH - 1);
  localparam int unsigned FRAC_BITS   = 14;

  // register indexes
  typedef enum logic [2:0] {
    REG_INPUT_CENTER  = 3'd0,
    REG_SCALE_GAIN    = 3'd1,
    REG_OUTPUT_CENTER = 3'd2,
    REG_OUTPUT_MIN    = 3'd3,
    REG_OUTPUT_MAX    = 3'd4
  } sbf_reg_t;

  // configuration as seen by the back end
  typedef struct packed {
    logic [10:0] input_center;
    logic [15:0] scale_gain;
    logic [11:0] output_center;
    logic [11:0] output_min;
    logic [11:0] output_max;
  } sbf_cfg_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } sbf_qstat_t;

  function automatic logic is_end_mark(input logic [7:0] b);
    return (b == END_BYTE) || (b[3:0] == END_NIBBLE);
  endfunction

endpackage

// ===== rtl/sbf_front.sv =====
// ----------------------------------------------------------------------------
// sbf_front
// Byte intake: header hunting, payload collection and footer check.
// ----------------------------------------------------------------------------
module sbf_front
  import sbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  input  sbf_qstat_t           qstat,
  output logic                 push,
  output logic [PAYLOAD_W-1:0] push_data
);

  logic [4:0]           frame_position;
  logic [7:0]           previous_byte;
  logic [PAYLOAD_W-1:0] payload;
  logic                 accept;

  // hold the footer beat while no queue slot is free
  assign in_stall  = (frame_position == FOOTER_SLOT) && qstat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = accept && (frame_position == FOOTER_SLOT) && is_end_mark(rx_byte);
  assign push_data = payload;

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      previous_byte  <= END_BYTE;
    end else if (accept) begin
      previous_byte <= rx_byte;
      if (frame_position == '0) begin
        if (rx_byte == HDR_BYTE && is_end_mark(previous_byte)) begin
          frame_position <= 5'd1;
        end
      end else if (frame_position < FOOTER_SLOT) begin
        frame_position <= frame_position + 5'd1;
      end else begin
        frame_position <= '0;
      end
    end
  end

  // payload bytes shift in from the top, byte 1 ends at the bottom
  always_ff @(posedge clk) begin
    if (accept && frame_position != '0 && frame_position <= 5'(PAYLOAD_LEN)) begin
      payload <= {rx_byte, payload[PAYLOAD_W-1:8]};
    end
  end

endmodule

// ===== rtl/sbf_queue.sv =====
// ----------------------------------------------------------------------------
// sbf_queue
// Short frame queue between intake and channel processing.
// ----------------------------------------------------------------------------
module sbf_queue
  import sbf_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [PAYLOAD_W-1:0] push_data,
  input  logic                 pop,
  output logic [PAYLOAD_W-1:0] pop_data,
  output sbf_qstat_t           qstat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [PAYLOAD_W-1:0] entries [DEPTH];
  logic [PW-1:0]        wptr;
  logic [PW-1:0]        rptr;
  logic [CW-1:0]        count;

  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);
  assign pop_data    = entries[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

// ===== rtl/sbf_back.sv =====
// ----------------------------------------------------------------------------
// sbf_back
// Channel unpacking, scaling and clamping, one channel per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module sbf_back
  import sbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  sbf_cfg_t             cfg,
  input  sbf_qstat_t           qstat,
  input  logic [PAYLOAD_W-1:0] frame,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           channel_index,
  output logic [11:0]          channel_value,
  output logic                 last_channel
);

  logic               adv;
  logic               issue;
  logic [3:0]         ch;
  logic [10:0]        raw;

  logic               s1_valid;
  logic signed [11:0] s1_d;
  logic [3:0]         s1_idx;

  logic               s2_valid;
  logic signed [28:0] s2_p;
  logic [3:0]         s2_idx;

  logic signed [28:0] p_biased;
  logic signed [14:0] q;
  logic signed [15:0] v;
  logic signed [15:0] v_hi;
  logic signed [15:0] v_clamped;

  // whole pipeline moves while the output register can take a beat
  assign adv   = !out_valid || !out_stall;
  assign issue = adv && !qstat.empty;
  assign pop   = issue && (ch == LAST_CH);
  assign raw   = frame[CH_W*ch +: CH_W];

  // channel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (issue) begin
      ch <= ch + 4'd1;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // truncation toward zero, offset and clamp
  always_comb begin
    p_biased  = s2_p + ((s2_p < 0) ? 29'sd16383 : 29'sd0);
    q         = 15'(p_biased >>> FRAC_BITS);
    v         = 16'(q) + $signed({4'b0, cfg.output_center});
    v_hi      = (v > $signed({4'b0, cfg.output_max})) ? $signed({4'b0, cfg.output_max}) : v;
    v_clamped = (v_hi < $signed({4'b0, cfg.output_min})) ?
                $signed({4'b0, cfg.output_min}) : v_hi;
  end

  // data stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d          <= $signed({1'b0, raw}) - $signed({1'b0, cfg.input_center});
      s1_idx        <= ch;
      s2_p          <= 29'(s1_d) * 29'($signed({1'b0, cfg.scale_gain}));
      s2_idx        <= s1_idx;
      channel_index <= s2_idx;
      channel_value <= v_clamped[11:0];
      last_channel  <= (s2_idx == LAST_CH);
    end
  end

endmodule

// ===== rtl/sbus_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Serial-bus frame decoder: 25-byte frames in, 16 scaled channels out.
// ----------------------------------------------------------------------------
// A received byte is taken in every cycle in which in_valid is high and the
// input is not stalled. Once a frame's footer passes the check, the frame
// waits in a QUEUE_DEPTH-entry queue and the back end turns it into 16
// channel beats, one per cycle while the output is not stalled, through a
// three-register pipeline (recentre, multiply, offset and clamp). The footer
// beat is stalled only while the queue is full. Registers are written through
// cfg_we, cfg_index and cfg_data and take effect at once; they are to be written
// only while no frame is being processed. No clearing pass follows reset.
module sbus_frame_decoder
  import sbf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  channel_index,
  output logic [11:0] channel_value,
  output logic        last_channel
);

  sbf_cfg_t             cfg;
  sbf_qstat_t           qstat;
  logic                 push;
  logic                 pop;
  logic [PAYLOAD_W-1:0] push_data;
  logic [PAYLOAD_W-1:0] pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_center  <= 11'd992;
      cfg.scale_gain    <= 16'd10240;
      cfg.output_center <= 12'd1500;
      cfg.output_min    <= 12'd1000;
      cfg.output_max    <= 12'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_CENTER:  cfg.input_center  <= cfg_data[10:0];
        REG_SCALE_GAIN:    cfg.scale_gain    <= cfg_data;
        REG_OUTPUT_CENTER: cfg.output_center <= cfg_data[11:0];
        REG_OUTPUT_MIN:    cfg.output_min    <= cfg_data[11:0];
        REG_OUTPUT_MAX:    cfg.output_max    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  sbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  sbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  sbf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .qstat         (qstat),
    .frame         (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
  );

endmodule

// ===== rtl/sbf_checker.sv =====
// ----------------------------------------------------------------------------
// sbf_checker
// Port-level checks of the frame decoder output stream.
// ----------------------------------------------------------------------------
module sbf_checker
  import sbf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  channel_index,
  input logic [11:0] channel_value,
  input logic        last_channel
);

  logic [3:0] expected_index;

  // channel expected on the next output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_index <= '0;
    end else if (out_valid && !out_stall) begin
      expected_index <= channel_index + 4'd1;
    end
  end

  // a stalled beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(channel_index)
      && $stable(channel_value) && $stable(last_channel))
    else $error("stalled output beat changed");

  // channels leave in order, frame after frame
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> channel_index == expected_index)
    else $error("channel out of order");

  // end-of-frame mark sits on the last channel only
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_channel == (channel_index == LAST_CH))
    else $error("last channel mark wrong");

  // nothing leaves straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat after reset");

endmodule

bind sbus_frame_decoder sbf_checker u_sbf_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .channel_index (channel_index),
  .channel_value (channel_value),
  .last_channel  (last_channel)
);

// ===== tb/tb_sbus_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_sbus_frame_decoder
// Self-checking bench for the serial-bus frame decoder.
// ----------------------------------------------------------------------------
// Received bytes are fed in bursts with random gaps while the channel output
// is stalled in changing patterns. A local model of the frame hunt, channel
// unpacking and fixed-point scaling predicts every channel beat, and each
// beat that leaves the block is compared field by field with the oldest
// prediction. Directed frames cover header qualification, bad footers,
// payload and register extremes and crossed clamp limits; a long output
// hold-off at random settings fills the frame queue and stalls the input.
// ----------------------------------------------------------------------------
module tb_sbus_frame_decoder;
  import sbf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // bytes after the header that are kept: 22 channel bytes and the flags byte
  localparam int unsigned BODY_BYTES     = PAYLOAD_LEN + 1;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES    = 1000;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned BACKLOG_FRAMES = 3;
  localparam logic [2:0]  FIRST_SPARE_REG = 3'(REG_OUTPUT_MAX) + 3'd1;
  localparam logic [2:0]  LAST_REG_SLOT   = 3'h7;

  // register values after reset
  localparam logic [10:0] RST_INPUT_CENTER  = 11'd992;
  localparam logic [15:0] RST_SCALE_GAIN    = 16'd10240;
  localparam logic [11:0] RST_OUTPUT_CENTER = 12'd1500;
  localparam logic [11:0] RST_OUTPUT_MIN    = 12'd1000;
  localparam logic [11:0] RST_OUTPUT_MAX    = 12'd2000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic [3:0]  chan;
    logic [11:0] value;
    logic        last;
  } chan_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  channel_index;
  logic [11:0] channel_value;
  logic        last_channel;

  // local copy of the registers
  logic [10:0] cfg_in_ctr  = RST_INPUT_CENTER;
  logic [15:0] cfg_gain    = RST_SCALE_GAIN;
  logic [11:0] cfg_out_ctr = RST_OUTPUT_CENTER;
  logic [11:0] cfg_min     = RST_OUTPUT_MIN;
  logic [11:0] cfg_max     = RST_OUTPUT_MAX;

  // local copy of the frame hunt
  logic [4:0]  hunt_slot = '0;
  logic [7:0]  prev_rx = END_BYTE;
  logic [7:0]  frame_buf [24];

  chan_beat_t  expected_channels [$];

  int unsigned mismatches = 0;
  int unsigned beats_checked = 0;
  int unsigned frames_decoded = 0;
  int unsigned frames_dropped = 0;
  int unsigned input_stalls = 0;
  int unsigned bytes_sent = 0;
  int unsigned framed_bytes = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_request = 0;
  int unsigned burst_left = 8;
  logic [7:0]  last_sent = END_BYTE;

  sbus_frame_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d channel beats outstanding", $time,
               expected_channels.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // footer or byte before a header
  function automatic logic marks_frame_end(input logic [7:0] b);
    return (b == END_BYTE) || (b[3:0] == END_NIBBLE);
  endfunction

  // recentre, scale by the Q2.14 gain toward zero, offset and clamp
  function automatic logic [11:0] scale_raw(input logic [10:0] raw);
    int d;
    int p;
    int q;
    int v;
    d = int'(raw) - int'(cfg_in_ctr);
    p = d * int'(cfg_gain);
    if (p < 0) q = -((-p) >>> FRAC_BITS);
    else q = p >>> FRAC_BITS;
    v = q + int'(cfg_out_ctr);
    if (v > int'(cfg_max)) v = int'(cfg_max);
    if (v < int'(cfg_min)) v = int'(cfg_min);
    return v[11:0];
  endfunction

  // advance the frame hunt by one accepted byte, queue the channels of a good frame
  task automatic decode_byte(input logic [7:0] b);
    logic [PAYLOAD_W-1:0] bits;
    chan_beat_t beat;
    if (hunt_slot == 5'd0) begin
      if (b == HDR_BYTE && marks_frame_end(prev_rx)) begin
        frame_buf[0] = b;
        hunt_slot = 5'd1;
      end
    end else if (hunt_slot < FOOTER_SLOT) begin
      frame_buf[hunt_slot] = b;
      hunt_slot = hunt_slot + 5'd1;
    end else begin
      hunt_slot = 5'd0;
      if (marks_frame_end(b)) begin
        for (int k = 0; k < PAYLOAD_LEN; k++) bits[8*k +: 8] = frame_buf[k+1];
        for (int ch = 0; ch < NUM_CH; ch++) begin
          beat.chan  = 4'(ch);
          beat.value = scale_raw(bits[CH_W*ch +: CH_W]);
          beat.last  = (4'(ch) == LAST_CH);
          expected_channels.push_back(beat);
        end
        frames_decoded++;
      end else begin
        frames_dropped++;
      end
    end
    prev_rx = b;
  endtask

  // predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin : scoreboard
    chan_beat_t want;
    if (!rst) begin
      if (in_valid && in_stall) input_stalls++;
      if (in_valid && !in_stall) decode_byte(rx_byte);
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (expected_channels.size() == 0) begin
          $display("%0t: unexpected beat, channel %0d value %0d last %0b", $time,
                   channel_index, channel_value, last_channel);
          mismatches++;
        end else begin
          want = expected_channels.pop_front();
          if (channel_index !== want.chan) begin
            $display("%0t: channel_index expected %0d actual %0d", $time,
                     want.chan, channel_index);
            mismatches++;
          end
          if (channel_value !== want.value) begin
            $display("%0t: channel_value (channel %0d) expected %0d actual %0d", $time,
                     want.chan, want.value, channel_value);
            mismatches++;
          end
          if (last_channel !== want.last) begin
            $display("%0t: last_channel (channel %0d) expected %0b actual %0b", $time,
                     want.chan, want.last, last_channel);
            mismatches++;
          end
        end
      end
    end
  end

  // output stall pattern, with a long hold-off on request
  initial begin : stall_gen
    stall_mode_t mode;
    int unsigned span;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(8, 64);
      while (span != 0) begin
        @(negedge clk);
        if (hold_request != 0) begin
          hold_left = hold_request;
          hold_request = 0;
        end
        if (hold_left != 0) begin
          out_stall <= 1'b1;
          hold_left--;
        end else begin
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
            default:     out_stall <= (span % 3 == 0);
          endcase
          span--;
        end
      end
    end
  end

  // one input beat, then maybe a gap closing the burst
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    last_sent = b;
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INPUT_CENTER:  cfg_in_ctr  = data[10:0];
      REG_SCALE_GAIN:    cfg_gain    = data;
      REG_OUTPUT_CENTER: cfg_out_ctr = data[11:0];
      REG_OUTPUT_MIN:    cfg_min     = data[11:0];
      REG_OUTPUT_MAX:    cfg_max     = data[11:0];
      default: ;
    endcase
  endtask

  // all five registers, with junk above the width of each register narrower than 16 bits
  task automatic set_config(input logic [10:0] ic, input logic [15:0] gain,
                            input logic [11:0] oc, input logic [11:0] lo,
                            input logic [11:0] hi);
    write_reg(REG_INPUT_CENTER, {5'($urandom), ic});
    write_reg(REG_SCALE_GAIN, gain);
    write_reg(REG_OUTPUT_CENTER, {4'($urandom), oc});
    write_reg(REG_OUTPUT_MIN, {4'($urandom), lo});
    write_reg(REG_OUTPUT_MAX, {4'($urandom), hi});
  endtask

  // drop valid and let every predicted beat drain out
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_channels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] valid_footer();
    return ($urandom_range(0, 2) == 0) ? END_BYTE : {4'($urandom), END_NIBBLE};
  endfunction

  function automatic logic [7:0] bad_footer();
    logic [7:0] b;
    b = 8'($urandom);
    while (marks_frame_end(b)) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [8*BODY_BYTES-1:0] random_body();
    logic [8*BODY_BYTES-1:0] body;
    case ($urandom_range(0, 5))
      0: body = '0;
      1: body = '1;
      default: for (int k = 0; k < BODY_BYTES; k++) body[8*k +: 8] = 8'($urandom);
    endcase
    return body;
  endfunction

  function automatic logic [15:0] pick_level(input logic [15:0] top);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return top;
      default: return 16'($urandom_range(0, top));
    endcase
  endfunction

  task automatic send_frame(input logic [8*BODY_BYTES-1:0] body, input logic [7:0] footer);
    send_byte(HDR_BYTE);
    for (int k = 0; k < BODY_BYTES; k++) send_byte(body[8*k +: 8]);
    send_byte(footer);
    framed_bytes += BODY_BYTES + 2;
  endtask

  // make the next header count
  task automatic ensure_qualified();
    if (!marks_frame_end(last_sent)) send_byte(valid_footer());
  endtask

  // header qualification and a full-scale payload at the reset settings
  task automatic test_frame_sync();
    send_byte(8'h23);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(8'h14);
    send_frame('1, 8'hF4);
    wait_idle();
  endtask

  // a bad footer drops the frame, and a header straight after it is ignored
  task automatic test_bad_footer();
    send_frame(random_body(), bad_footer());
    send_byte(HDR_BYTE);
    send_byte(END_NIBBLE);
    send_frame({BODY_BYTES{HDR_BYTE}}, END_BYTE);
    wait_idle();
  endtask

  task automatic run_config_case(input logic [10:0] ic, input logic [15:0] gain,
                                 input logic [11:0] oc, input logic [11:0] lo,
                                 input logic [11:0] hi);
    set_config(ic, gain, oc, lo, hi);
    ensure_qualified();
    send_frame(random_body(), valid_footer());
    wait_idle();
  endtask

  // register extremes and crossed clamp limits
  task automatic test_config_extremes();
    run_config_case('0, '1, '0, '0, '1);
    // minimum above maximum: minimum wins
    run_config_case(11'd1024, 16'd16384, 12'd2048, 12'd3000, 12'd1000);
  endtask

  // long output hold-off at random settings while frames keep coming, so the
  // queue fills; a write to a spare index goes in first and must change nothing
  task automatic test_backpressure();
    set_config(11'(pick_level(16'h07FF)), pick_level(16'hFFFF),
               12'(pick_level(16'h0FFF)), 12'(pick_level(16'h0FFF)),
               12'(pick_level(16'h0FFF)));
    write_reg(3'($urandom_range(FIRST_SPARE_REG, LAST_REG_SLOT)), 16'($urandom));
    hold_request = HOLD_CYCLES;
    repeat (BACKLOG_FRAMES) begin
      ensure_qualified();
      send_frame(random_body(), valid_footer());
    end
    wait_idle();
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_frame_sync();
    test_bad_footer();
    test_config_extremes();
    test_backpressure();
    $display("run covered %0d bytes (%0d in frames): %0d frames decoded, %0d dropped",
             bytes_sent, framed_bytes, frames_decoded, frames_dropped);
    $display("%0d channel beats checked, input held off for %0d cycles",
             beats_checked, input_stalls);
    if (mismatches == 0 && expected_channels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
